// File: design/shp_pkg.sv
package shp_pkg;

   localparam int BinCountDefault    = 32;
   localparam int ColumnCountDefault = 64;
   localparam int SampleWidth        = 16;
   localparam int BinIndexWidth      = 5;

   // Input action codes
   localparam logic ActPush    = 1'b0;
   localparam logic ActSummary = 1'b1;

   // Controller states
   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOAD,
      ST_SCAN,
      ST_EMIT
   } state_type;

   // Controller to datapath commands
   typedef struct packed {
      logic clear_step;   // write zero at the sweep address, advance sweep
      logic push;         // write accepted sample, advance bin/column pointers
      logic start_bin;    // reset bin select for a new summary
      logic load_cand;    // latch the candidate value from memory
      logic scan_step;    // compare one history entry against the candidate
      logic next_cand;    // advance to the next candidate column
      logic next_bin;     // advance to the next frequency bin
      logic emit;         // load result register
   } ctrl_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic clear_done;
      logic scan_done;    // registered: the last entry of the row has been compared
      logic cand_hit;     // candidate sits at the wanted rank
      logic last_bin;
   } ctrl_sts_type;

endpackage

// File: design/shp_if.sv
interface shp_req_if;
   logic        valid;
   logic        ready;
   logic        action;
   logic [15:0] sample;

   modport source (output valid, output action, output sample, input ready);
   modport sink   (input valid, input action, input sample, output ready);
endinterface

interface shp_rsp_if;
   logic        valid;
   logic        ready;
   logic [4:0]  bin_index;
   logic [15:0] percentile_value;
   logic        last;

   modport source (output valid, output bin_index, output percentile_value,
                   output last, input ready);
   modport sink   (input valid, input bin_index, input percentile_value,
                   input last, output ready);
endinterface

// File: design/shp_datapath.sv
module shp_datapath #(
   parameter int BIN_COUNT    = shp_pkg::BinCountDefault,
   parameter int COLUMN_COUNT = shp_pkg::ColumnCountDefault
) (
   input  logic                  clock,
   input  logic                  reset,
   input  shp_pkg::ctrl_cmd_type cmd,
   output shp_pkg::ctrl_sts_type sts,
   input  logic signed [15:0]    push_sample,
   output logic [4:0]            res_bin,
   output logic signed [15:0]    res_value
);
   localparam int FW = (BIN_COUNT > 1) ? $clog2(BIN_COUNT) : 1;
   localparam int TW = $clog2(COLUMN_COUNT);
   localparam int AW = FW + TW;
   localparam int Depth = BIN_COUNT * COLUMN_COUNT;
   localparam int Rank = COLUMN_COUNT * 5 / 100;
   localparam int CW = TW + 1;

   logic signed [15:0] mem [Depth];
   logic signed [15:0] rd_ff;

   logic [AW-1:0] sweep_ff, sweep_in;
   logic [FW-1:0] wbin_ff, wbin_in;
   logic [TW-1:0] col_ff, col_in;
   logic [FW-1:0] sbin_ff, sbin_in;
   logic [TW-1:0] cand_ff, cand_in;
   logic [TW-1:0] scol_ff, scol_in;
   logic [CW-1:0] less_ff, less_in, leq_ff, leq_in;
   logic signed [15:0] cval_ff;
   logic [TW-1:0] rcol;
   logic [AW-1:0] raddr, waddr;
   logic          we;
   logic signed [15:0] wdata;
   logic scan_last_ff;

   // Read address: next scan column while loading or scanning, else the candidate
   always_comb begin
      rcol  = (cmd.load_cand || cmd.scan_step) ? scol_in : cand_in;
      raddr = AW'(sbin_in) * AW'(COLUMN_COUNT) + AW'(rcol);
   end

   always_comb begin
      we    = cmd.clear_step || cmd.push;
      wdata = cmd.clear_step ? 16'sd0 : push_sample;
      waddr = cmd.clear_step ? sweep_ff
                             : AW'(wbin_ff) * AW'(COLUMN_COUNT) + AW'(col_ff);
   end

   // History memory, registered read
   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      rd_ff <= mem[raddr];
   end

   always_comb begin
      sweep_in = sweep_ff;
      wbin_in  = wbin_ff;
      col_in   = col_ff;
      if (cmd.clear_step) sweep_in = sweep_ff + AW'(1);
      if (cmd.push) begin
         if (32'(wbin_ff) == BIN_COUNT - 1) begin
            wbin_in = '0;
            col_in  = (32'(col_ff) == COLUMN_COUNT - 1) ? '0 : col_ff + TW'(1);
         end else begin
            wbin_in = wbin_ff + FW'(1);
         end
      end
   end

   // Selection by counting: for each candidate scan the whole row
   always_comb begin
      sbin_in = sbin_ff;
      cand_in = cand_ff;
      scol_in = scol_ff;
      less_in = less_ff;
      leq_in  = leq_ff;
      if (cmd.start_bin) begin
         sbin_in = '0;
         cand_in = '0;
      end
      if (cmd.next_bin) begin
         sbin_in = sbin_ff + FW'(1);
         cand_in = '0;
      end
      if (cmd.next_cand) cand_in = cand_ff + TW'(1);
      if (cmd.load_cand) begin
         scol_in = '0;
         less_in = '0;
         leq_in  = '0;
      end
      if (cmd.scan_step) begin
         scol_in = (32'(scol_ff) == COLUMN_COUNT - 1) ? '0 : scol_ff + TW'(1);
         if (rd_ff < cval_ff)  less_in = less_ff + CW'(1);
         if (rd_ff <= cval_ff) leq_in  = leq_ff + CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sweep_ff <= '0;
         wbin_ff  <= '0;
         col_ff   <= '0;
         sbin_ff  <= '0;
         cand_ff  <= '0;
         scol_ff  <= '0;
         less_ff  <= '0;
         leq_ff   <= '0;
         scan_last_ff <= 1'b0;
      end else begin
         sweep_ff <= sweep_in;
         wbin_ff  <= wbin_in;
         col_ff   <= col_in;
         sbin_ff  <= sbin_in;
         cand_ff  <= cand_in;
         scol_ff  <= scol_in;
         less_ff  <= less_in;
         leq_ff   <= leq_in;
         scan_last_ff <= cmd.scan_step && (32'(scol_ff) == COLUMN_COUNT - 1);
      end
   end

   // Hold candidate value and result
   always_ff @(posedge clock) begin
      if (cmd.load_cand) cval_ff <= rd_ff;
      if (cmd.emit) begin
         res_bin   <= 5'(sbin_ff);
         res_value <= cval_ff;
      end
   end

   // scan_done is registered: raised in the cycle after the final compare, when counts settle
   always_comb begin
      sts.clear_done = 32'(sweep_ff) == Depth - 1;
      sts.scan_done  = scan_last_ff;
      sts.cand_hit   = (32'(less_ff) <= Rank) && (Rank < 32'(leq_ff));
      sts.last_bin   = 32'(sbin_ff) == BIN_COUNT - 1;
   end

`ifndef ASSERT_OFF
   a_no_write_clash: assert property (@(posedge clock) disable iff (reset)
      !(cmd.clear_step && cmd.push))
      else $error("clear and push in one cycle");
   a_counts_ordered: assert property (@(posedge clock) disable iff (reset)
      less_ff <= leq_ff)
      else $error("less count above leq count");
   a_candidate_found: assert property (@(posedge clock) disable iff (reset)
      (sts.scan_done && 32'(cand_ff) == COLUMN_COUNT - 1) |-> sts.cand_hit)
      else $error("no candidate at rank");
`endif
endmodule

// File: design/shp_ctrl.sv
module shp_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_action,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic                  rsp_last,
   output shp_pkg::ctrl_cmd_type cmd,
   input  shp_pkg::ctrl_sts_type sts
);
   shp_pkg::state_type state_ff, state_in;
   logic rv_ff, rv_in, rl_ff, rl_in;
   logic req_xfer, rsp_xfer, load_wait_ff;
   logic is_summary;

   assign req_xfer   = req_valid && req_ready;
   assign rsp_xfer   = rv_ff && rsp_ready;
   assign is_summary = req_action == shp_pkg::ActSummary;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         shp_pkg::ST_CLEAR: if (sts.clear_done) state_in = shp_pkg::ST_IDLE;
         shp_pkg::ST_IDLE:  if (req_xfer && is_summary) state_in = shp_pkg::ST_LOAD;
         shp_pkg::ST_LOAD:  if (!load_wait_ff) state_in = shp_pkg::ST_SCAN;
         shp_pkg::ST_SCAN: begin
            if (sts.scan_done) begin
               if (sts.cand_hit) state_in = shp_pkg::ST_EMIT;
               else state_in = shp_pkg::ST_LOAD;
            end
         end
         shp_pkg::ST_EMIT: begin
            if (!rv_ff || rsp_ready) begin
               if (sts.last_bin) state_in = shp_pkg::ST_IDLE;
               else state_in = shp_pkg::ST_LOAD;
            end
         end
         default: state_in = shp_pkg::ST_IDLE;
      endcase
   end

   // Outputs
   always_comb begin
      cmd = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         shp_pkg::ST_CLEAR: cmd.clear_step = 1'b1;
         shp_pkg::ST_IDLE: begin
            req_ready = !rv_ff;
            cmd.push      = req_xfer && !is_summary;
            cmd.start_bin = req_xfer && is_summary;
         end
         shp_pkg::ST_LOAD: cmd.load_cand = !load_wait_ff;
         shp_pkg::ST_SCAN: begin
            cmd.scan_step = !sts.scan_done;
            cmd.next_cand = sts.scan_done && !sts.cand_hit;
         end
         shp_pkg::ST_EMIT: begin
            cmd.emit     = !rv_ff || rsp_ready;
            cmd.next_bin = cmd.emit && !sts.last_bin;
         end
         default: cmd = '0;
      endcase
   end

   always_comb begin
      rv_in = rv_ff;
      rl_in = rl_ff;
      if (rsp_xfer) rv_in = 1'b0;
      if (cmd.emit) begin
         rv_in = 1'b1;
         rl_in = sts.last_bin;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= shp_pkg::ST_CLEAR;
         rv_ff        <= 1'b0;
         rl_ff        <= 1'b0;
         load_wait_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rv_ff        <= rv_in;
         rl_ff        <= rl_in;
         // wait for the registered read of a new address
         load_wait_ff <= (state_in == shp_pkg::ST_LOAD) && (state_ff != shp_pkg::ST_LOAD);
      end
   end

   assign rsp_valid = rv_ff;
   assign rsp_last  = rl_ff;

`ifndef ASSERT_OFF
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> state_ff == shp_pkg::ST_IDLE)
      else $error("input taken outside idle");
   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> (!rv_ff || rsp_ready))
      else $error("result overwritten");
   a_clear_blocks: assert property (@(posedge clock) disable iff (reset)
      state_ff == shp_pkg::ST_CLEAR |-> !req_ready)
      else $error("input taken during clear");
`endif
endmodule

// File: design/spectral_history_percentile_unit.sv
// Channel | Dir | Payload                                  | Transfer
// req     | in  | action, sample                           | valid && ready
// rsp     | out | bin_index, percentile_value, last        | valid && ready
//
// A summary tries, for each bin, k candidate columns until one sits at the rank (at most
// COLUMN_COUNT); each candidate is compared against every entry of the bin's row.
// After reset a clearing pass writes zero to all BIN_COUNT*COLUMN_COUNT entries,
// one per cycle, with req_ready low. A stalled rsp holds the result and the scan.
module spectral_history_percentile_unit #(
   parameter int BIN_COUNT    = shp_pkg::BinCountDefault,
   parameter int COLUMN_COUNT = shp_pkg::ColumnCountDefault
) (
   input logic clock,
   input logic reset,
   shp_req_if.sink   req,
   shp_rsp_if.source rsp
);
   shp_pkg::ctrl_cmd_type cmd;
   shp_pkg::ctrl_sts_type sts;

   shp_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req.valid),
      .req_action (req.action),
      .req_ready  (req.ready),
      .rsp_valid  (rsp.valid),
      .rsp_ready  (rsp.ready),
      .rsp_last   (rsp.last),
      .cmd        (cmd),
      .sts        (sts)
   );

   shp_datapath #(.BIN_COUNT(BIN_COUNT), .COLUMN_COUNT(COLUMN_COUNT)) u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .sts         (sts),
      .push_sample (req.sample),
      .res_bin     (rsp.bin_index),
      .res_value   (rsp.percentile_value)
   );
endmodule

// File: dv/testbench.sv
`default_nettype none

module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NumBins   = shp_pkg::BinCountDefault;
   localparam int NumCols   = shp_pkg::ColumnCountDefault;
   localparam int FloorRank = NumCols * 5 / 100;
   localparam int StallLimit = 20000;
   localparam int HoldCycles = 400;

   typedef enum logic [1:0] {
      IDLE_NONE,
      IDLE_SEND,
      IDLE_RECV,
      IDLE_BOTH
   } idle_mode_type;

   typedef struct {
      logic          action;
      logic [15:0]   sample;
      idle_mode_type mode;
      bit            hold_off;
   } spectrum_item_type;

   typedef struct {
      logic [4:0]  bin_index;
      logic [15:0] value;
      logic        last;
   } floor_result_type;

   logic clock;
   logic reset = 1'b1;

   shp_req_if req_bus ();
   shp_rsp_if rsp_bus ();

   spectral_history_percentile_unit uut (
      .clock (clock),
      .reset (reset),
      .req   (req_bus),
      .rsp   (rsp_bus)
   );

   spectrum_item_type pending_items[$];
   floor_result_type  expected_floors[$];

   // Predictor state
   logic signed [15:0] spectrum_history[NumBins][NumCols];
   int unsigned        write_col;
   int unsigned        write_bin;

   idle_mode_type cur_mode = IDLE_NONE;
   bit            hold_request = 0;
   int            hold_left = 0;
   bit            req_taken = 0;
   int            error_count = 0;
   int            quiet_cycles = 0;

   // Clock
   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   task automatic report_mismatch(input string msg);
      $display("ERROR %0t: %s", $realtime, msg);
      error_count++;
   endtask

   // 5th-percentile value of one bin's history (sorted copy, pick the rank)
   function automatic logic signed [15:0] bin_floor(input int bin);
      logic signed [15:0] sorted[NumCols];
      logic signed [15:0] tmp;
      int j;
      for (int i = 0; i < NumCols; i++) sorted[i] = spectrum_history[bin][i];
      for (int i = 1; i < NumCols; i++) begin
         tmp = sorted[i];
         j = i - 1;
         while (j >= 0 && sorted[j] > tmp) begin
            sorted[j + 1] = sorted[j];
            j--;
         end
         sorted[j + 1] = tmp;
      end
      return sorted[FloorRank];
   endfunction

   task automatic apply_transfer(input logic action, input logic [15:0] sample);
      floor_result_type res;
      if (action == shp_pkg::ActPush) begin
         spectrum_history[write_bin][write_col] = sample;
         write_bin++;
         if (write_bin >= NumBins) begin
            write_bin = 0;
            write_col = (write_col + 1) % NumCols;
         end
      end else begin
         for (int b = 0; b < NumBins; b++) begin
            res.bin_index = b[4:0];
            res.value     = bin_floor(b);
            res.last      = (b == NumBins - 1);
            expected_floors.push_back(res);
         end
      end
   endtask

   function automatic bit roll(input int pct);
      return $urandom_range(99) < pct;
   endfunction

   // Predict on accepted input, check accepted results, watchdog
   always @(posedge clock) begin
      floor_result_type want;
      req_taken <= !reset && req_bus.valid && req_bus.ready;
      if (reset) begin
         quiet_cycles <= 0;
      end else begin
         if (req_bus.valid && req_bus.ready)
            apply_transfer(req_bus.action, req_bus.sample);
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_floors.size() == 0) begin
               report_mismatch($sformatf("unexpected result bin %0d", rsp_bus.bin_index));
            end else begin
               want = expected_floors.pop_front();
               if (rsp_bus.bin_index !== want.bin_index)
                  report_mismatch($sformatf("bin_index got %0d want %0d",
                                            rsp_bus.bin_index, want.bin_index));
               if (rsp_bus.percentile_value !== want.value)
                  report_mismatch($sformatf("bin %0d value got %h want %h",
                                            want.bin_index, rsp_bus.percentile_value,
                                            want.value));
               if (rsp_bus.last !== want.last)
                  report_mismatch($sformatf("bin %0d last got %b want %b",
                                            want.bin_index, rsp_bus.last, want.last));
            end
         end
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
            quiet_cycles <= 0;
         else
            quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= StallLimit) begin
            $display("timeout: no transfer for %0d cycles", StallLimit);
            $display("CHECK FAILED");
            $finish;
         end
      end
   end

   // Drive requests from the pending queue
   always @(negedge clock) begin
      spectrum_item_type item;
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else if (!req_bus.valid || req_taken) begin
         if (pending_items.size() > 0 &&
             !((cur_mode == IDLE_SEND && roll(74)) || (cur_mode == IDLE_BOTH && roll(13))))
         begin
            item = pending_items.pop_front();
            cur_mode = item.mode;
            if (item.hold_off) hold_request = 1;
            req_bus.valid  <= 1'b1;
            req_bus.action <= item.action;
            req_bus.sample <= item.sample;
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // Drive result backpressure; hold off for a long stretch once results show up after a hold-off item
   always @(negedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else if (hold_request && rsp_bus.valid) begin
         hold_request = 0;
         hold_left = HoldCycles;
         rsp_bus.ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= !((cur_mode == IDLE_RECV && roll(74)) ||
                            (cur_mode == IDLE_BOTH && roll(13)));
      end
   end

   task automatic queue_item(input logic action, input logic [15:0] sample,
                             input idle_mode_type mode, input bit hold_off = 0);
      spectrum_item_type item;
      item.action   = action;
      item.sample   = sample;
      item.mode     = mode;
      item.hold_off = hold_off;
      pending_items.push_back(item);
   endtask

   // Random sample: mostly negative so the low rank picks written data
   function automatic logic [15:0] random_sample();
      if (roll(60)) return 16'h8000 | 16'($urandom_range(16'h7fff));
      return 16'($urandom);
   endfunction

   initial begin
      idle_mode_type mode;
      int n_frames;
      req_bus.valid  = 1'b0;
      req_bus.action = shp_pkg::ActPush;
      req_bus.sample = '0;
      rsp_bus.ready  = 1'b0;
      write_col = 0;
      write_bin = 0;
      mode = IDLE_NONE;
      for (int b = 0; b < NumBins; b++)
         for (int c = 0; c < NumCols; c++) spectrum_history[b][c] = '0;

      // Directed: summary of the cleared store, extremes, summary mid-frame
      queue_item(shp_pkg::ActSummary, 16'h0000, IDLE_NONE);
      queue_item(shp_pkg::ActPush, 16'h7fff, IDLE_NONE);
      queue_item(shp_pkg::ActPush, 16'h8000, IDLE_NONE);
      queue_item(shp_pkg::ActPush, 16'h0000, IDLE_NONE);
      queue_item(shp_pkg::ActPush, 16'hffff, IDLE_NONE);
      queue_item(shp_pkg::ActPush, 16'h0001, IDLE_NONE);
      queue_item(shp_pkg::ActPush, 16'h5555, IDLE_NONE);
      queue_item(shp_pkg::ActPush, 16'haaaa, IDLE_NONE);
      queue_item(shp_pkg::ActPush, 16'h8001, IDLE_NONE);
      queue_item(shp_pkg::ActSummary, 16'hffff, IDLE_NONE);
      for (int i = 0; i < 12; i++)
         queue_item(shp_pkg::ActPush, (i % 2) ? 16'h8000 : 16'hff00, IDLE_NONE);

      // Random: whole frames of pushes, summaries between or inside frames
      n_frames = 0;
      while (n_frames < 3) begin
         for (int i = 0; i < NumBins; i++) begin
            // spread the four idling phases evenly over the pushes
            mode = idle_mode_type'(((n_frames * NumBins + i) * 4) / (3 * NumBins));
            queue_item(shp_pkg::ActPush, random_sample(), mode);
            if (roll(2))
               queue_item(shp_pkg::ActSummary, 16'($urandom), mode, n_frames == 1);
         end
         queue_item(shp_pkg::ActSummary, 16'($urandom), mode, n_frames == 1);
         n_frames++;
      end

      reset = 1'b1;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      wait (pending_items.size() == 0 && !req_bus.valid && expected_floors.size() == 0);
      repeat (50) @(posedge clock);
      if (error_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule

`default_nettype wire

// File: sim.f
design/shp_pkg.sv
design/shp_if.sv
design/shp_datapath.sv
design/shp_ctrl.sv
design/spectral_history_percentile_unit.sv
dv/testbench.sv
